// ----- rtl/varint_codec_32_64_assert.svh -----
// Assertion macros used by the varint codec checker.
`ifndef VARINT_CODEC_32_64_ASSERT_SVH
`define VARINT_CODEC_32_64_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define VC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("varint codec: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define VC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("varint codec: next-cycle check failed");

`endif

// ----- rtl/vc_pkg.sv -----
// Shared types and constants of the varint codec.
package vc_pkg;

   // Operating mode carried with each input transaction
   typedef enum logic [1:0] {
      MODE_ENC32 = 2'd0,
      MODE_ENC64 = 2'd1,
      MODE_DEC32 = 2'd2,
      MODE_DEC64 = 2'd3
   } mode_type;

   // Result kind carried on rsp_tuser
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ENDED    = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   // Group limits per width
   localparam logic [3:0] GROUPS_32 = 4'd5;
   localparam logic [3:0] GROUPS_64 = 4'd10;

   // One encode step of the group unit
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } enc_out_type;

endpackage

// ----- rtl/vc_group_unit.sv -----
// Shared 7-bit group unit: splits one group off for encode, inserts one for decode.
module vc_group_unit
   import vc_pkg::*;
(
   input  logic [63:0] enc_word,
   input  logic [63:0] acc,
   input  logic [3:0]  grp_idx,
   input  logic [7:0]  in_byte,
   output enc_out_type enc_out,
   output logic [63:0] enc_word_next,
   output logic [63:0] dec_acc
);

   logic        more;
   logic [6:0]  shamt;
   logic [63:0] ins;

   // Encode: low group out, continuation when higher bits remain
   always_comb begin
      more                 = |enc_word[63:7];
      enc_out.out_byte     = {more, enc_word[6:0]};
      enc_out.last         = !more;
      enc_word_next        = {7'd0, enc_word[63:7]};
   end

   // Decode: place the group at 7 * index, drop bits above 63
   always_comb begin
      shamt   = {grp_idx, 3'd0} - {3'd0, grp_idx};
      ins     = {57'd0, in_byte[6:0]} << shamt[5:0];
      dec_acc = (grp_idx < GROUPS_64) ? (acc | ins) : acc;
   end

endmodule

// ----- rtl/varint_codec_32_64.sv -----
// Top level of the LEB128 varint codec for 32-bit and 64-bit values.
//
//  channel | dir | tdata                                  | tuser            | tlast
//  req_    | in  | [63:0] value, [71:64] in_byte          | [1:0] mode,      | -
//          |     |                                        | [2] data_end     |
//  rsp_    | out | [7:0] out_byte, [71:8] out_value,      | [1:0] kind       | last
//          |     | [73:72] error_code, [79:74] zero       |                  |
//
// Decode takes one byte per cycle while the output is free; the result lands in the output register.
// Encode gives n output bytes (1..5 or 1..10): it first loads the work register,
// then emits one byte per free output slot through the shared group unit.
// An output stall holds the sequencer; req_tready is low while encoding.
// Synchronous reset clears the sequencer state, the decode state and the output valid.
module varint_codec_32_64
   import vc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] value, [71:64] in_byte
   input  logic [2:0]  req_tuser,   // [1:0] mode, [2] data_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] out_byte, [71:8] out_value, [73:72] error_code
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   typedef enum logic {
      ST_IDLE,
      ST_ENCODE
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] enc_word_ff, enc_word_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  gc_ff, gc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic [1:0]  rsp_err_ff, rsp_err_in;
   logic        rsp_last_ff, rsp_last_in;

   mode_type    mode;
   logic [63:0] value;
   logic [7:0]  in_byte;
   logic        data_end;
   logic        is_decode;
   logic        wide;
   logic        rsp_free;
   logic        accept;
   logic [3:0]  gc_next;
   logic [3:0]  limit;

   enc_out_type enc_out;
   logic [63:0] enc_word_next;
   logic [63:0] dec_acc;

   // Unpack the request
   assign value     = req_tdata[63:0];
   assign in_byte   = req_tdata[71:64];
   assign mode      = mode_type'(req_tuser[1:0]);
   assign data_end  = req_tuser[2];
   assign is_decode = (mode == MODE_DEC32) || (mode == MODE_DEC64);
   assign wide      = (mode == MODE_ENC64) || (mode == MODE_DEC64);

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign gc_next    = gc_ff + 4'd1;
   assign limit      = wide ? GROUPS_64 : GROUPS_32;

   vc_group_unit u_group (
      .enc_word      (enc_word_ff),
      .acc           (acc_ff),
      .grp_idx       (gc_ff),
      .in_byte       (in_byte),
      .enc_out       (enc_out),
      .enc_word_next (enc_word_next),
      .dec_acc       (dec_acc)
   );

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      enc_word_in  = enc_word_ff;
      acc_in       = acc_ff;
      gc_in        = gc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      // Drop the output once the transaction completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_decode) begin
               // Load the value to encode
               enc_word_in = wide ? value : {32'd0, value[31:0]};
               state_in    = ST_ENCODE;
            end else if (accept) begin
               rsp_kind_in  = KIND_ERROR;
               rsp_byte_in  = 8'd0;
               rsp_value_in = 64'd0;
               rsp_err_in   = ERR_NONE;
               rsp_last_in  = 1'b1;
               priority if (data_end) begin
                  // End of data: error only inside a varint
                  if (gc_ff != 4'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_err_in   = ERR_ENDED;
                     acc_in       = 64'd0;
                     gc_in        = 4'd0;
                  end
               end else if (!in_byte[7]) begin
                  // Final group: emit the value
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_VALUE;
                  rsp_value_in = wide ? dec_acc : {32'd0, dec_acc[31:0]};
                  acc_in       = 64'd0;
                  gc_in        = 4'd0;
               end else if (gc_next >= limit) begin
                  // Continuation past the limit
                  rsp_valid_in = 1'b1;
                  rsp_err_in   = ERR_TOO_LONG;
                  acc_in       = 64'd0;
                  gc_in        = 4'd0;
               end else begin
                  acc_in = dec_acc;
                  gc_in  = gc_next;
               end
            end
         end
         ST_ENCODE: begin
            // Emit one byte per free output slot
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BYTE;
               rsp_byte_in  = enc_out.out_byte;
               rsp_value_in = 64'd0;
               rsp_err_in   = ERR_NONE;
               rsp_last_in  = enc_out.last;
               enc_word_in  = enc_word_next;
               if (enc_out.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      enc_word_ff  <= enc_word_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= 64'd0;
         gc_ff        <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_err_ff, rsp_value_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/vc_checker.sv -----
// Port-level checks of the varint codec, bound to the top level.
`include "varint_codec_32_64_assert.svh"

module vc_checker
   import vc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled response holds its payload
   `VC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // Errors always close the transaction group
   `VC_ASSERT_SAME(a_error_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_ERROR), rsp_tlast)

   // An encoded byte is last exactly when it has no continuation bit
   `VC_ASSERT_SAME(a_byte_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_BYTE), rsp_tlast == !rsp_tdata[7])

   // No new request is taken in the middle of an encoded run
   `VC_ASSERT_SAME(a_run_busy, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready)

endmodule

bind varint_codec_32_64 vc_checker u_vc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
